@@ rtl/craf_pkg.sv @@
package craf_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 20;
  localparam logic [CNT_W-1:0] BAN_COUNT = CNT_W'(100000);
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_EXPIRY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CNT_FLOOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_NUM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_DEN  = 3'd4;

  // Item actions
  localparam logic [1:0] ACT_DENY  = 2'd0;
  localparam logic [1:0] ACT_PROXY = 2'd1;
  localparam logic [1:0] ACT_CHECK = 2'd2;

  // Result reasons
  localparam logic [2:0] RSN_OK    = 3'd0;
  localparam logic [2:0] RSN_DENY  = 3'd1;
  localparam logic [2:0] RSN_PROXY = 3'd2;
  localparam logic [2:0] RSN_GAP   = 3'd3;
  localparam logic [2:0] RSN_RATE  = 3'd4;
  localparam logic [2:0] RSN_ZERO  = 3'd5;
  localparam logic [2:0] RSN_LOAD  = 3'd6;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  slot;
    logic [31:0] address;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic             refuse;
    logic [2:0]       reason;
    logic [CNT_W-1:0] attempt_count;
  } result_t;

  typedef struct packed {
    logic [31:0]      address;
    logic [31:0]      first;
    logic [31:0]      last;
    logic [CNT_W-1:0] count;
  } track_row_t;

  // Controller to datapath
  typedef struct packed {
    logic       capture;
    logic       scan_start;
    logic       scan_deny;
    logic       scan_proxy;
    logic       scan_track;
    logic       clear_row;
    logic       load_row;
    logic       fin_simple;
    logic [2:0] fin_reason;
    logic       miss_row;
    logic       upd_a;
    logic       upd_b;
    logic       upd_c;
    logic       out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic act_load;
    logic act_check;
    logic zero_octet;
    logic list_hit;
    logic list_miss;
    logic track_hit;
    logic track_end;
  } sts_t;

endpackage

@@ rtl/connection_rate_admission_filter.sv @@
// Loads, unused actions and zero-octet checks go from accept through the dispatch and finish states to the result.
// A check scans deny list, proxy list and tracking table one entry a cycle
// through one registered RAM read port each.
// One item is in work at a time; the next is accepted the cycle after a result
// is registered, while that result may still wait on result_stall.
// Reset: synchronous; a clearing pass then zeroes all tables.
module connection_rate_admission_filter import craf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  craf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  craf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

endmodule

@@ rtl/craf_ram.sv @@
module craf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/craf_datapath.sv @@
module craf_datapath import craf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  item_t                 item,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output result_t               result
);

  localparam logic [IDX_W:0]   DEPTH_N  = (IDX_W+1)'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // Configuration registers
  logic [15:0] expiry;
  logic [7:0]  min_gap;
  logic [9:0]  cnt_floor;
  logic [7:0]  rate_num;
  logic [7:0]  rate_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      expiry    <= 16'd3600;
      min_gap   <= 8'd1;
      cnt_floor <= 10'd10;
      rate_num  <= 8'd5;
      rate_den  <= 8'd18;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_EXPIRY:    expiry    <= cfg_data;
        REG_MIN_GAP:   min_gap   <= cfg_data[7:0];
        REG_CNT_FLOOR: cnt_floor <= cfg_data[9:0];
        REG_RATE_NUM:  rate_num  <= cfg_data[7:0];
        REG_RATE_DEN:  rate_den  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Current item
  item_t cur;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= item;
    end
  end

  // Sweep counter and read pipeline
  logic [IDX_W:0]   idx;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic             scanning;

  assign scanning = cmd.scan_deny | cmd.scan_proxy | cmd.scan_track;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.scan_start) begin
      idx    <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.clear_row) begin
      idx <= idx + 1'b1;
    end else if (scanning) begin
      rd_vld <= (idx < DEPTH_N);
      if (idx < DEPTH_N) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= idx[IDX_W-1:0];
  end

  // Memories
  logic             slot_ok;
  logic [IDX_W-1:0] slot_idx;
  logic             deny_we, proxy_we;
  logic [IDX_W-1:0] list_waddr;
  logic [31:0]      list_wdata;
  logic [31:0]      deny_q, proxy_q;

  assign slot_ok    = (32'(cur.slot) < 32'(TABLE_DEPTH));
  assign slot_idx   = IDX_W'(cur.slot);
  assign deny_we    = cmd.clear_row
                      | (cmd.load_row & slot_ok & (cur.action == ACT_DENY));
  assign proxy_we   = cmd.clear_row
                      | (cmd.load_row & slot_ok & (cur.action == ACT_PROXY));
  assign list_waddr = cmd.clear_row ? idx[IDX_W-1:0] : slot_idx;
  assign list_wdata = cmd.clear_row ? 32'd0 : cur.address;

  craf_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_deny (
    .clk   (clk),
    .we    (deny_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (idx[IDX_W-1:0]),
    .rdata (deny_q)
  );

  craf_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_proxy (
    .clk   (clk),
    .we    (proxy_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (idx[IDX_W-1:0]),
    .rdata (proxy_q)
  );

  logic             trk_we;
  logic [IDX_W-1:0] trk_waddr;
  track_row_t       trk_wdata;
  track_row_t       trk_q;

  craf_ram #(.WIDTH($bits(track_row_t)), .DEPTH(TABLE_DEPTH)) u_track (
    .clk   (clk),
    .we    (trk_we),
    .waddr (trk_waddr),
    .wdata (trk_wdata),
    .raddr (idx[IDX_W-1:0]),
    .rdata (trk_q)
  );

  // List lookup
  logic [31:0] list_q;
  logic        list_vld;
  assign list_q   = cmd.scan_deny ? deny_q : proxy_q;
  assign list_vld = rd_vld & (cmd.scan_deny | cmd.scan_proxy);

  // Tracking entry test
  logic signed [32:0] age;
  logic               stale;
  logic               match;
  logic               trk_vld;

  assign age     = $signed({1'b0, cur.now}) - $signed({1'b0, trk_q.last});
  assign stale   = age > $signed({17'd0, expiry});
  assign match   = !stale && (trk_q.address == cur.address);
  assign trk_vld = rd_vld & cmd.scan_track;

  // Least-recent candidate and matched entry
  logic [IDX_W-1:0] cand;
  logic [31:0]      cand_last;
  logic [IDX_W-1:0] h_idx;
  track_row_t       h_row;
  logic             h_gap;

  always_ff @(posedge clk) begin
    if (trk_vld && !match) begin
      if (rd_idx == '0 || trk_q.last < cand_last) begin
        cand      <= rd_idx;
        cand_last <= trk_q.last;
      end
    end
    if (trk_vld && match) begin
      h_idx <= rd_idx;
      h_row <= trk_q;
      h_gap <= (age <= $signed({25'd0, min_gap}));
    end
  end

  // Update pipeline: increment, multiply, compare
  logic [CNT_W-1:0]   cnt_new;
  logic signed [32:0] span;
  logic [27:0]        lhs;
  logic [39:0]        rhs;
  logic               span_zero, span_neg;
  logic               ban;

  always_ff @(posedge clk) begin
    if (cmd.upd_a) begin
      cnt_new <= (h_row.count != COUNT_MAX) ? h_row.count + 1'b1 : h_row.count;
      span    <= $signed({1'b0, cur.now}) - $signed({1'b0, h_row.first});
    end
    if (cmd.upd_b) begin
      lhs       <= cnt_new * rate_den;
      rhs       <= rate_num * span[31:0];
      span_zero <= (span == '0);
      span_neg  <= span[32];
    end
  end

  assign ban = (cnt_new >= CNT_W'(cnt_floor))
               && (span_zero || (!span_neg && (40'(lhs) >= rhs)));

  // Tracking table writes
  always_comb begin
    trk_we    = 1'b0;
    trk_waddr = rd_idx;
    trk_wdata = trk_q;
    trk_wdata.address[7:0] = 8'd0;
    if (cmd.clear_row) begin
      trk_we    = 1'b1;
      trk_waddr = idx[IDX_W-1:0];
      trk_wdata = '0;
    end else if (trk_vld && stale) begin
      trk_we = 1'b1;
    end else if (cmd.upd_c) begin
      trk_we          = 1'b1;
      trk_waddr       = h_idx;
      trk_wdata       = h_row;
      trk_wdata.last  = cur.now;
      trk_wdata.count = ban ? BAN_COUNT : cnt_new;
    end else if (cmd.miss_row) begin
      trk_we            = 1'b1;
      trk_waddr         = cand;
      trk_wdata.address = cur.address;
      trk_wdata.first   = cur.now;
      trk_wdata.last    = cur.now;
      trk_wdata.count   = CNT_W'(1);
    end
  end

  // Finished result and output register
  result_t fin;
  always_ff @(posedge clk) begin
    if (cmd.fin_simple) begin
      fin.refuse        <= (cmd.fin_reason == RSN_DENY);
      fin.reason        <= cmd.fin_reason;
      fin.attempt_count <= '0;
    end else if (cmd.miss_row) begin
      fin.refuse        <= 1'b0;
      fin.reason        <= RSN_OK;
      fin.attempt_count <= CNT_W'(1);
    end else if (cmd.upd_c) begin
      fin.refuse        <= ban | h_gap;
      fin.reason        <= ban ? RSN_RATE : (h_gap ? RSN_GAP : RSN_OK);
      fin.attempt_count <= ban ? BAN_COUNT : cnt_new;
    end
    if (cmd.out_load) begin
      result <= fin;
    end
  end

  // Status
  always_comb begin
    sts.clear_last = (idx[IDX_W-1:0] == LAST_IDX);
    sts.act_load   = (cur.action == ACT_DENY) || (cur.action == ACT_PROXY);
    sts.act_check  = (cur.action == ACT_CHECK);
    sts.zero_octet = (cur.address[7:0] == 8'd0);
    sts.list_hit   = list_vld && (list_q[7:0] != 8'd0) && (list_q == cur.address);
    sts.list_miss  = list_vld && ((list_q[7:0] == 8'd0)
                     || ((list_q != cur.address) && (rd_idx == LAST_IDX)));
    sts.track_hit  = trk_vld && match;
    sts.track_end  = trk_vld && !match && (rd_idx == LAST_IDX);
  end

endmodule

@@ rtl/craf_ctrl.sv @@
module craf_ctrl import craf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  output logic result_valid,
  input  logic result_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_DENY, S_PROXY, S_TRACK,
    S_UPD_A, S_UPD_B, S_UPD_C, S_MISS, S_FINISH
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_row = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.capture = item_valid;
        if (item_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.act_load) begin
          cmd.load_row   = 1'b1;
          cmd.fin_simple = 1'b1;
          cmd.fin_reason = RSN_LOAD;
          state_next     = S_FINISH;
        end else if (!sts.act_check) begin
          cmd.fin_simple = 1'b1;
          cmd.fin_reason = RSN_LOAD;
          state_next     = S_FINISH;
        end else if (sts.zero_octet) begin
          cmd.fin_simple = 1'b1;
          cmd.fin_reason = RSN_ZERO;
          state_next     = S_FINISH;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_DENY;
        end
      end
      S_DENY: begin
        cmd.scan_deny = 1'b1;
        if (sts.list_hit) begin
          cmd.fin_simple = 1'b1;
          cmd.fin_reason = RSN_DENY;
          state_next     = S_FINISH;
        end else if (sts.list_miss) begin
          cmd.scan_start = 1'b1;
          state_next     = S_PROXY;
        end
      end
      S_PROXY: begin
        cmd.scan_proxy = 1'b1;
        if (sts.list_hit) begin
          cmd.fin_simple = 1'b1;
          cmd.fin_reason = RSN_PROXY;
          state_next     = S_FINISH;
        end else if (sts.list_miss) begin
          cmd.scan_start = 1'b1;
          state_next     = S_TRACK;
        end
      end
      S_TRACK: begin
        cmd.scan_track = 1'b1;
        if (sts.track_hit) begin
          state_next = S_UPD_A;
        end else if (sts.track_end) begin
          state_next = S_MISS;
        end
      end
      S_UPD_A: begin
        cmd.upd_a  = 1'b1;
        state_next = S_UPD_B;
      end
      S_UPD_B: begin
        cmd.upd_b  = 1'b1;
        state_next = S_UPD_C;
      end
      S_UPD_C: begin
        cmd.upd_c  = 1'b1;
        state_next = S_FINISH;
      end
      S_MISS: begin
        cmd.miss_row = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_drop_only_taken: assert property (@(posedge clk) disable iff (rst)
    $fell(result_valid) |-> $past(!result_stall))
    else $error("result beat dropped while stalled");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (state == S_DISPATCH))
    else $error("accepted beat not dispatched");

  a_track_excl: assert property (@(posedge clk) disable iff (rst)
    !(sts.track_hit && sts.track_end))
    else $error("track scan hit and end together");

  a_list_excl: assert property (@(posedge clk) disable iff (rst)
    !(sts.list_hit && sts.list_miss))
    else $error("list scan hit and miss together");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (item_stall && !result_valid))
    else $error("activity during clearing pass");

endmodule
